### sv/krt_pkg.sv
package krt_pkg;

    // Field and register widths fixed by the interface
    localparam int CHAR_W     = 8;
    localparam int KEY_LEN_W  = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LETTER_W   = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 2'd0,
        CFG_KEY_LEN   = 2'd1,
        CFG_KEY_LOW   = 2'd2,
        CFG_KEY_HIGH  = 2'd3
    } cfg_index_t;

    // Operating mode
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

endpackage

### sv/krt_ram.sv
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/keyed_row_transposition_core.sv
// Keyed row transposition: bytes fill a row of key-length slots, then the row
// is sent out in key-rank order (encode) or back in key order (decode).
// Throughput: one byte a cycle while a row fills; input then holds while the row drains.
// Bytes pass through the registered reads of the rank, map and row memories.
// Reset, and every configuration write, starts a rank pass over the key columns with no byte taken.
module keyed_row_transposition_core
    import krt_pkg::*;
#(
    parameter int KEY_MAX = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] in_char
    input  logic                  s_axis_tlast,   // in_last
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] out_char
    output logic                  m_axis_tlast,   // out_last
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W = $clog2(KEY_MAX + 1);

    // Sequencer states
    localparam logic [2:0] S_RANK  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SW_A  = 3'd2;
    localparam logic [2:0] S_SW_B  = 3'd3;
    localparam logic [2:0] S_ENC_C = 3'd4;
    localparam logic [2:0] S_DEC_A = 3'd5;
    localparam logic [2:0] S_DEC_B = 3'd6;
    localparam logic [2:0] S_DEC_C = 3'd7;

    // Configuration registers
    logic                  mode_reg, mode_next;
    logic [KEY_LEN_W-1:0]  key_length_reg, key_length_next;
    logic [CFG_DATA_W-1:0] key_low_reg, key_low_next;
    logic [CFG_DATA_W-1:0] key_high_reg, key_high_next;

    // Control registers
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] rj_reg, rj_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] j_reg, j_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    // Memory ports
    logic             inv_we, inv_re;
    logic [IDX_W-1:0] inv_waddr, inv_wdata, inv_raddr, inv_rdata;
    logic              row_we, row_re;
    logic [IDX_W-1:0]  row_waddr, row_raddr;
    logic [CHAR_W-1:0] row_rdata;
    logic             map_we, map_re;
    logic [IDX_W-1:0] map_waddr, map_wdata, map_raddr, map_rdata;

    logic [CNT_W-1:0]    k_len;
    logic [2*CFG_DATA_W-1:0] key_bytes;
    logic [LETTER_W-1:0] letter [KEY_MAX];
    logic [LETTER_W-1:0] cur_letter;
    logic [CNT_W-1:0]    rank_sum;
    logic                out_free;
    logic                s_accept;
    logic                r_at_end;

    // Inverse rank table: column for each rank
    krt_ram #(.WIDTH(IDX_W), .DEPTH(KEY_MAX)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .re    (inv_re),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    // Row store
    krt_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (s_axis_tdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Decode map: row slot for each key position of a row
    krt_ram #(.WIDTH(IDX_W), .DEPTH(KEY_MAX)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Clamp the key length into one to KEY_MAX
    always_comb
    begin
        priority if (key_length_reg == '0)
        begin
            k_len = CNT_W'(1);
        end
        else if (key_length_reg > KEY_LEN_W'(KEY_MAX))
        begin
            k_len = CNT_W'(KEY_MAX);
        end
        else
        begin
            k_len = CNT_W'(key_length_reg);
        end
    end

    // Split the key registers into letters
    assign key_bytes = {key_high_reg, key_low_reg};

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            letter[i] = key_bytes[LETTER_W*i +: LETTER_W];
        end
    end

    assign cur_letter = letter[rj_reg];

    // Stable rank of the current column: smaller letters plus earlier equal ones
    always_comb
    begin
        rank_sum = '0;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if ((CNT_W'(i) < k_len) &&
                ((letter[i] < cur_letter) ||
                 ((letter[i] == cur_letter) && (IDX_W'(i) < rj_reg))))
            begin
                rank_sum = rank_sum + CNT_W'(1);
            end
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign r_at_end      = (CNT_W'(r_reg) + CNT_W'(1)) == k_len;

    // Sequencer
    always_comb
    begin
        mode_next       = mode_reg;
        key_length_next = key_length_reg;
        key_low_next    = key_low_reg;
        key_high_next   = key_high_reg;
        state_next      = state_reg;
        rj_next         = rj_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        j_next          = j_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;

        inv_we    = 1'b0;
        inv_waddr = rank_sum[IDX_W-1:0];
        inv_wdata = rj_reg;
        inv_re    = 1'b0;
        inv_raddr = r_reg;
        row_we    = 1'b0;
        row_waddr = fill_reg[IDX_W-1:0];
        row_re    = 1'b0;
        row_raddr = inv_rdata;
        map_we    = 1'b0;
        map_waddr = inv_rdata;
        map_wdata = c_reg;
        map_re    = 1'b0;
        map_raddr = j_reg;

        unique case (state_reg)
            S_RANK:
            begin
                // Store the column under its rank, one column a cycle
                inv_we = 1'b1;
                if ((CNT_W'(rj_reg) + CNT_W'(1)) == k_len)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rj_next = rj_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                // Take a byte into the row; a full row or the last byte closes it
                if (s_accept)
                begin
                    row_we = 1'b1;
                    if (((fill_reg + CNT_W'(1)) == k_len) || s_axis_tlast)
                    begin
                        n_next     = fill_reg + CNT_W'(1);
                        last_next  = s_axis_tlast;
                        fill_next  = '0;
                        r_next     = '0;
                        c_next     = '0;
                        j_next     = '0;
                        state_next = S_SW_A;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end

            S_SW_A:
            begin
                // Look up the column of this rank
                inv_re     = 1'b1;
                state_next = S_SW_B;
            end

            S_SW_B:
            begin
                if (CNT_W'(inv_rdata) < n_reg)
                begin
                    if (mode_reg == MODE_ENCODE)
                    begin
                        row_re     = 1'b1;
                        state_next = S_ENC_C;
                    end
                    else
                    begin
                        // Record the relative rank of this key position
                        map_we = 1'b1;
                        c_next = c_reg + IDX_W'(1);
                        if (r_at_end)
                        begin
                            state_next = S_DEC_A;
                        end
                        else
                        begin
                            r_next     = r_reg + IDX_W'(1);
                            state_next = S_SW_A;
                        end
                    end
                end
                else
                begin
                    // Drop columns the short row does not reach
                    if (r_at_end)
                    begin
                        state_next = (mode_reg == MODE_ENCODE) ? S_IDLE : S_DEC_A;
                    end
                    else
                    begin
                        r_next     = r_reg + IDX_W'(1);
                        state_next = S_SW_A;
                    end
                end
            end

            S_ENC_C:
            begin
                // Hand the byte to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = row_rdata;
                    out_last_next  = last_reg &&
                                     ((CNT_W'(c_reg) + CNT_W'(1)) == n_reg);
                    c_next         = c_reg + IDX_W'(1);
                    if (r_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + IDX_W'(1);
                        state_next = S_SW_A;
                    end
                end
            end

            S_DEC_A:
            begin
                map_re     = 1'b1;
                state_next = S_DEC_B;
            end

            S_DEC_B:
            begin
                row_re     = 1'b1;
                row_raddr  = map_rdata;
                state_next = S_DEC_C;
            end

            S_DEC_C:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = row_rdata;
                    out_last_next  = last_reg &&
                                     ((CNT_W'(j_reg) + CNT_W'(1)) == n_reg);
                    if ((CNT_W'(j_reg) + CNT_W'(1)) == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_DEC_A;
                    end
                end
            end
        endcase

        // A register write reloads the ranks and drops a partial row
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:     mode_next       = cfg_data[0];
                CFG_KEY_LEN:  key_length_next = cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_LOW:  key_low_next    = cfg_data;
                CFG_KEY_HIGH: key_high_next   = cfg_data;
            endcase
            state_next = S_RANK;
            rj_next    = '0;
            fill_next  = '0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENCODE;
            key_length_reg <= KEY_LEN_W'(1);
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            state_reg      <= S_RANK;
            rj_reg         <= '0;
            fill_reg       <= '0;
            n_reg          <= '0;
            last_reg       <= 1'b0;
            r_reg          <= '0;
            c_reg          <= '0;
            j_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            key_length_reg <= key_length_next;
            key_low_reg    <= key_low_next;
            key_high_reg   <= key_high_next;
            state_reg      <= state_next;
            rj_reg         <= rj_next;
            fill_reg       <= fill_next;
            n_reg          <= n_next;
            last_reg       <= last_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            j_reg          <= j_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // A partial row never reaches the key length while waiting for bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg < k_len))
        else $error("row fill reached key length while idle");

    // A closed row is never empty nor longer than the key
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_A) |-> ((n_reg != '0) && (n_reg <= k_len)))
        else $error("row length out of range during sweep");

    // Encode never sends more bytes than the row holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENC_C) |-> (CNT_W'(c_reg) < n_reg))
        else $error("encode sweep sent more bytes than the row holds");

endmodule

### tb/sv/krt_stream_checker.sv
`timescale 1ns / 100ps

module krt_stream_checker
    import krt_pkg::*;
#(
    parameter int KEY_MAX = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] in_char
    input  logic                  s_axis_tlast,   // in_last
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] out_char
    input  logic                  m_axis_tlast,   // out_last
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    checked_count
);

    typedef struct packed {
        logic [CHAR_W-1:0] text;
        logic              last;
    } text_byte_t;

    text_byte_t              expected_bytes[$];
    text_byte_t              oldest;

    // Shadow copy of the register file and the row being gathered
    logic                    mode_q;
    logic [KEY_LEN_W-1:0]    key_len_q;
    logic [CFG_DATA_W-1:0]   key_low_q;
    logic [CFG_DATA_W-1:0]   key_high_q;
    logic [3:0]              rank_of_column [KEY_MAX];
    logic [CHAR_W-1:0]       slot_bytes [KEY_MAX];
    int                      slots_filled;

    // Clamp the key length to 1..KEY_MAX
    function automatic int active_columns();
        if (key_len_q == '0)
            return 1;
        if (int'(key_len_q) > KEY_MAX)
            return KEY_MAX;
        return int'(key_len_q);
    endfunction

    function automatic logic [LETTER_W-1:0] key_letter(int j);
        if (j < 8)
            return key_low_q[j*LETTER_W +: LETTER_W];
        return key_high_q[(j-8)*LETTER_W +: LETTER_W];
    endfunction

    // Stable sort rank per column; ties go to the earlier column
    function automatic void rerank_columns();
        int k;
        int r;
        k = active_columns();
        for (int j = 0; j < KEY_MAX; j++)
        begin
            r = 0;
            if (j < k)
                for (int i = 0; i < k; i++)
                    if (key_letter(i) < key_letter(j) ||
                        (key_letter(i) == key_letter(j) && i < j))
                        r++;
            rank_of_column[j] = r[3:0];
        end
        slots_filled = 0;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (cfg_index_t'(idx))
            CFG_MODE:     mode_q     = data[0];
            CFG_KEY_LEN:  key_len_q  = data[KEY_LEN_W-1:0];
            CFG_KEY_LOW:  key_low_q  = data;
            CFG_KEY_HIGH: key_high_q = data;
        endcase
        rerank_columns();
    endfunction

    // Store one byte; on a full or final row, queue the permuted row
    function automatic void absorb_text(logic [CHAR_W-1:0] text, logic last);
        int                k;
        int                n;
        int                cnt;
        int                idx;
        logic [CHAR_W-1:0] row_out [KEY_MAX];
        text_byte_t        item;
        k = active_columns();
        if (slots_filled >= k)
            slots_filled = 0;
        slot_bytes[slots_filled] = text;
        slots_filled++;
        if (slots_filled < k && !last)
            return;
        n   = slots_filled;
        cnt = 0;
        if (mode_q == MODE_ENCODE)
        begin
            for (int r = 0; r < k; r++)
                for (int j = 0; j < n; j++)
                    if (int'(rank_of_column[j]) == r)
                    begin
                        row_out[cnt] = slot_bytes[j];
                        cnt++;
                    end
        end
        else
        begin
            // Decode: place each byte by rank relative to the columns present
            for (int j = 0; j < n; j++)
            begin
                idx = 0;
                for (int i = 0; i < n; i++)
                    if (rank_of_column[i] < rank_of_column[j])
                        idx++;
                row_out[cnt] = slot_bytes[idx % KEY_MAX];
                cnt++;
            end
        end
        for (int i = 0; i < cnt; i++)
        begin
            item.text = row_out[i];
            item.last = last && (i == cnt - 1);
            expected_bytes.push_back(item);
        end
        slots_filled = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = MODE_ENCODE;
            key_len_q  = KEY_LEN_W'(1);
            key_low_q  = '0;
            key_high_q = '0;
            for (int j = 0; j < KEY_MAX; j++)
                slot_bytes[j] = '0;
            rerank_columns();
            expected_bytes.delete();
            mismatch_count = 0;
            pending_count  = 0;
            checked_count  = 0;
        end
        else
        begin
            // Compare each result request with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual char %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    checked_count++;
                    if (m_axis_tdata !== oldest.text)
                    begin
                        mismatch_count++;
                        $display("%0t: out_char mismatch, expected %h, actual %h",
                                 $time, oldest.text, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        mismatch_count++;
                        $display("%0t: out_last mismatch, expected %b, actual %b",
                                 $time, oldest.last, m_axis_tlast);
                    end
                end
            end
            // Track register writes, then the text request
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                absorb_text(s_axis_tdata, s_axis_tlast);
            pending_count = expected_bytes.size();
        end
    end

endmodule

### tb/sv/keyed_row_transposition_core_test.sv
`timescale 1ns / 100ps

module keyed_row_transposition_core_test
    import krt_pkg::*;
();

    localparam int KEY_MAX        = 16;
    localparam int TEXT_ITEMS     = 330;
    localparam int SETTLE_CYCLES  = 2*KEY_MAX + 3*KEY_MAX + 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [CHAR_W-1:0]     DASH  = 8'h2D;
    // Key "BANAN": repeated letters give tied ranks
    localparam logic [CFG_DATA_W-1:0] BANAN = 64'h0000_004E_414E_4142;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata  = '0;   // [7:0] in_char
    logic                  s_axis_tlast  = 1'b0; // in_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;         // [7:0] out_char
    logic                  m_axis_tlast;         // out_last
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int idle_cycles      = 0;
    int items_sent       = 0;
    int settings_written = 0;
    int columns          = 1;
    bit burst_mode       = 1'b0;
    bit hold_request     = 1'b0;

    keyed_row_transposition_core #(
        .KEY_MAX       (KEY_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    krt_stream_checker #(
        .KEY_MAX        (KEY_MAX)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Abort when no request of any kind moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no request for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    function automatic int columns_for(logic [KEY_LEN_W-1:0] len);
        if (len == '0)
            return 1;
        if (int'(len) > KEY_MAX)
            return KEY_MAX;
        return int'(len);
    endfunction

    function automatic logic [CHAR_W-1:0] random_text();
        if ($urandom_range(0, 5) == 0)
            return DASH;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Mostly short keys, with the clamped and maximum lengths mixed in
    function automatic logic [KEY_LEN_W-1:0] random_key_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return KEY_LEN_W'(KEY_MAX);
            2:       return KEY_LEN_W'($urandom_range(17, 31));
            default: return KEY_LEN_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Narrow alphabet, all-zero or all-ones words most of the time so that ties are common
    function automatic logic [CFG_DATA_W-1:0] random_key_word();
        logic [CFG_DATA_W-1:0] word;
        case ($urandom_range(0, 4))
            0:       word = '0;
            1:       word = '1;
            4:       word = {$urandom, $urandom};
            default:
                for (int b = 0; b < 8; b++)
                    word[b*LETTER_W +: LETTER_W] = LETTER_W'(8'h41 + $urandom_range(0, 3));
        endcase
        return word;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_written++;
        if (idx == CFG_KEY_LEN)
            columns = columns_for(data[KEY_LEN_W-1:0]);
    endtask

    // Offer one text request after a random gap and wait for acceptance
    task automatic send_text(logic [CHAR_W-1:0] text, logic last);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
            send_text(random_text(), i == len - 1);
    endtask

    // Drop valid, drain all expected results, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int partial;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: encode with one column, byte extremes
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        settle();

        // Tied key, letters above the key length ignored; full row then short row
        write_reg(CFG_KEY_LOW, BANAN);
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(5));
        send_text(8'h48, 1'b0);
        send_text(8'h45, 1'b0);
        send_text(DASH, 1'b0);
        send_text(8'h4C, 1'b0);
        send_text(8'h4F, 1'b0);
        send_text(8'h58, 1'b0);
        send_text(8'h80, 1'b1);
        settle();

        // Decode: exact multiple ending on a full row, then a short row
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECODE));
        send_text(8'h01, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(DASH, 1'b0);
        send_text(8'hFE, 1'b0);
        send_text(8'h10, 1'b1);
        send_text(8'h55, 1'b0);
        send_text(8'hAA, 1'b1);
        settle();

        // Zero key length acts as one column
        write_reg(CFG_KEY_LEN, '0);
        send_text(8'h5A, 1'b1);
        settle();

        // Partly filled row, discarded by the next write
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCODE));
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(5));
        send_text(8'h33, 1'b0);
        send_text(8'hCC, 1'b0);
        send_text(DASH, 1'b0);
        settle();
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(31));

        // Random phases: a new setting, a few messages, sometimes a broken row
        phase = 0;
        while (items_sent < TEXT_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(CFG_KEY_LEN, CFG_DATA_W'(random_key_length()));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(CFG_KEY_LOW, random_key_word());
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(CFG_KEY_HIGH, random_key_word());
            if (phase == 2 || phase == 11)
            begin
                // Long receiver hold-off while text keeps coming
                hold_request = 1'b1;
                send_message(3*columns + $urandom_range(1, columns));
            end
            repeat ($urandom_range(1, 3))
                send_message($urandom_range(1, 3*columns));
            if (columns > 1 && $urandom_range(0, 5) == 0)
            begin
                partial = $urandom_range(1, columns - 1);
                repeat (partial)
                    send_text(random_text(), 1'b0);
            end
            settle();
            phase++;
        end
        settle();

        $display("Sent %0d text bytes over %0d phases and %0d register writes",
                 items_sent, phase, settings_written);
        $display("Compared %0d result bytes, encode and decode, key lengths 0 to 31",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/krt_pkg.sv
sv/krt_ram.sv
sv/keyed_row_transposition_core.sv
tb/sv/krt_stream_checker.sv
tb/sv/keyed_row_transposition_core_test.sv
